// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the tokenizer RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slt_pkg.sv =====
// ---------------------------------------------------------------------------
// slt_pkg
// Types, token codes and character tables for the source line tokenizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package slt_pkg;

    localparam int MAX_RES = 4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_SYM
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_SYM  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        K_IDENT, K_INT, K_BOOL,
        K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_SEMI, K_COMMA,
        K_ASSIGN, K_PLUS, K_MINUS, K_STAR, K_SLASH,
        K_EQ, K_LT, K_GT, K_OR, K_AND, K_XOR,
        K_STRUCT, K_IF, K_WHILE, K_FOR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [31:0] value;
        logic        ovf;
        logic [9:0]  col;
        logic [10:0] len;
    } tok_t;

    // up to two results from closing a token
    typedef struct packed {
        logic [1:0] vld;
        logic       err;
        tok_t       r0;
        tok_t       r1;
    } fin_t;

    // all results of one character
    typedef struct packed {
        logic [2:0]              cnt;
        tok_t [MAX_RES-1:0]      tok;
    } bundle_t;

    // K_IDENT means "not a symbol that stands alone"
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ";":     k = K_SEMI;
            ",":     k = K_COMMA;
            "=":     k = K_ASSIGN;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "<":     k = K_LT;
            ">":     k = K_GT;
            "^":     k = K_XOR;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    // keyword bit order: struct, if, while, for, true, false
    function automatic logic [5:0] word_hit(input logic [7:0] c, input logic [2:0] pos);
        logic [5:0] h;
        case (pos)
            3'd0:    h = {c == "f", c == "t", c == "f", c == "w", c == "i", c == "s"};
            3'd1:    h = {c == "a", c == "r", c == "o", c == "h", c == "f", c == "t"};
            3'd2:    h = {c == "l", c == "u", c == "r", c == "i", 1'b0, c == "r"};
            3'd3:    h = {c == "s", c == "e", 1'b0, c == "l", 1'b0, c == "u"};
            3'd4:    h = {c == "e", 1'b0, 1'b0, c == "e", 1'b0, c == "c"};
            3'd5:    h = {5'b0, c == "t"};
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic logic [5:0] word_len_hit(input logic [2:0] len);
        return {len == 3'd5, len == 3'd4, len == 3'd3, len == 3'd5, len == 3'd2, len == 3'd6};
    endfunction

endpackage

// ===== rtl/core/slt_lexer.sv =====
// ---------------------------------------------------------------------------
// slt_lexer
// Per-character scanner state and result assembly for one character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slt_lexer
    import slt_pkg::*;
#(
    parameter int MAX_LINE = 1024,
    parameter int INT_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] char_code,
    input  logic       line_end,
    output bundle_t    bundle_o
);

    localparam int COL_W = $clog2(MAX_LINE);
    localparam int CW1   = COL_W + 1;
    localparam int RUN_W = $clog2(MAX_LINE + 1);
    localparam int AW    = INT_BITS + 4;

    mode_t                mode_reg, mode_c, mode_p, mode_next;
    logic [5:0]           match_reg, match_p;
    logic [COL_W-1:0]     col_reg, col_next, start_reg, start_p;
    logic [RUN_W-1:0]     run_reg, run_p, run_next, run_inc;
    logic [INT_BITS-1:0]  acc_reg, acc_p;
    logic                 ovf_reg, ovf_p;
    logic [7:0]           pa_reg, pa_p, pb_reg, pb_p;
    logic                 skip_reg, skip_p, skip_next;
    logic [AW-1:0]        acc_wide, acc_mul;
    logic                 is_alpha, is_digit, is_sym, is_space, is_bad;
    logic                 fin_go, proc_go, end_go;
    fin_t                 fin_a, fin_e;
    tok_t                 ps0, ps1, ps2;
    logic [2:0]           ps_vld;
    logic                 ps_err;
    tok_t                 cand [7];
    logic [6:0]           cand_vld;

    function automatic tok_t tok_make(input kind_t k, input status_t s,
                                      input logic [31:0] v, input logic o,
                                      input logic [CW1-1:0] col,
                                      input logic [RUN_W-1:0] len);
        tok_t t;
        t.kind   = k;
        t.status = s;
        t.value  = v;
        t.ovf    = o;
        t.col    = 10'(col);
        t.len    = 11'(len);
        return t;
    endfunction

    function automatic tok_t sym_tok(input logic [7:0] c, input logic [CW1-1:0] col);
        kind_t k;
        k = single_kind(c);
        return tok_make(k, (k == K_IDENT) ? ST_BAD_SYM : ST_OK, 32'd0, 1'b0, col,
                        RUN_W'(1));
    endfunction

    // close the open token
    function automatic fin_t finish(input mode_t m, input logic [5:0] match,
                                    input logic [RUN_W-1:0] run,
                                    input logic [COL_W-1:0] start,
                                    input logic [INT_BITS-1:0] acc, input logic ovf,
                                    input logic [7:0] pa, input logic [7:0] pb);
        fin_t       f;
        logic [5:0] hits;
        kind_t      k;
        logic       v;
        f    = '0;
        hits = (run < RUN_W'(8)) ? (match & word_len_hit(run[2:0])) : 6'b0;
        k    = K_IDENT;
        v    = 1'b0;
        unique case (m)
            MODE_WORD: begin
                if (hits[0]) k = K_STRUCT;
                else if (hits[1]) k = K_IF;
                else if (hits[2]) k = K_WHILE;
                else if (hits[3]) k = K_FOR;
                else if (hits[4]) begin
                    k = K_BOOL;
                    v = 1'b1;
                end else if (hits[5]) k = K_BOOL;
                f.vld = 2'b01;
                f.r0  = tok_make(k, ST_OK, {31'd0, v}, 1'b0, CW1'(start), run);
            end
            MODE_NUM: begin
                f.vld = 2'b01;
                f.r0  = tok_make(K_INT, ST_OK, 32'(acc), ovf, CW1'(start), run);
            end
            MODE_SYM: begin
                if (run == RUN_W'(1)) begin
                    f.vld = 2'b01;
                    f.r0  = sym_tok(pb, CW1'(start));
                    f.err = (f.r0.status == ST_BAD_SYM);
                end else if (run == RUN_W'(2)) begin
                    f.vld = 2'b01;
                    if (pa == "=" && pb == "=") begin
                        f.r0 = tok_make(K_EQ, ST_OK, 32'd0, 1'b0, CW1'(start), RUN_W'(2));
                    end else if (pa == "|" && pb == "|") begin
                        f.r0 = tok_make(K_OR, ST_OK, 32'd0, 1'b0, CW1'(start), RUN_W'(2));
                    end else if (pa == "&" && pb == "&") begin
                        f.r0 = tok_make(K_AND, ST_OK, 32'd0, 1'b0, CW1'(start), RUN_W'(2));
                    end else begin
                        f.r0 = sym_tok(pa, CW1'(start));
                        f.r1 = sym_tok(pb, CW1'(start) + 1'b1);
                        if (f.r0.status == ST_BAD_SYM) begin
                            f.err = 1'b1;
                        end else begin
                            f.vld = 2'b11;
                            f.err = (f.r1.status == ST_BAD_SYM);
                        end
                    end
                end
            end
            MODE_IDLE: f = '0;
        endcase
        return f;
    endfunction

    // character classes, token close on entry, symbol emits
    always_comb begin
        is_alpha = (char_code >= "a" && char_code <= "z") ||
                   (char_code >= "A" && char_code <= "Z");
        is_digit = (char_code >= "0" && char_code <= "9");
        is_sym   = (single_kind(char_code) != K_IDENT) || char_code == "|" ||
                   char_code == "&";
        is_space = (char_code == " ");
        is_bad   = !is_space && !is_alpha && !is_digit && !is_sym;

        fin_a  = finish(mode_reg, match_reg, run_reg, start_reg, acc_reg, ovf_reg,
                        pa_reg, pb_reg);
        fin_go = !skip_reg && ((mode_reg == MODE_WORD && !is_alpha && !is_digit) ||
                               (mode_reg == MODE_NUM && !is_digit) ||
                               (mode_reg == MODE_SYM && !is_sym));
        proc_go = !skip_reg && !(fin_go && fin_a.err);
        mode_c  = fin_go ? MODE_IDLE : mode_reg;
        run_inc = (run_reg < RUN_W'(MAX_LINE)) ? run_reg + 1'b1 : run_reg;

        ps0    = sym_tok(pa_reg, CW1'(start_reg));
        ps1    = sym_tok(pb_reg, CW1'(start_reg) + 1'b1);
        ps2    = sym_tok(char_code, CW1'(col_reg));
        ps_vld = 3'b000;
        ps_err = 1'b0;
        if (proc_go && mode_c == MODE_SYM && run_reg == RUN_W'(2)) begin
            // third symbol of a run: flush all three singly, stopping after a bad one
            ps_vld[0] = 1'b1;
            ps_vld[1] = ps0.status != ST_BAD_SYM;
            ps_vld[2] = ps_vld[1] && ps1.status != ST_BAD_SYM;
            ps_err    = (ps0.status == ST_BAD_SYM) ||
                        (ps_vld[1] && ps1.status == ST_BAD_SYM) ||
                        (ps_vld[2] && ps2.status == ST_BAD_SYM);
        end else if (proc_go && mode_c == MODE_SYM && run_reg > RUN_W'(2)) begin
            ps0       = sym_tok(char_code, CW1'(col_reg));
            ps_vld[0] = 1'b1;
            ps_err    = ps0.status == ST_BAD_SYM;
        end else if (proc_go && mode_c == MODE_IDLE && is_bad) begin
            ps0       = tok_make(K_IDENT, ST_BAD_CHAR, 32'd0, 1'b0, CW1'(col_reg),
                                 RUN_W'(1));
            ps_vld[0] = 1'b1;
            ps_err    = 1'b1;
        end

        acc_wide = AW'(acc_reg);
        acc_mul  = (acc_wide << 3) + (acc_wide << 1) + AW'(char_code[3:0]);
    end

    // state after this character
    always_comb begin
        mode_p  = mode_c;
        match_p = match_reg;
        start_p = start_reg;
        run_p   = run_reg;
        acc_p   = acc_reg;
        ovf_p   = ovf_reg;
        pa_p    = pa_reg;
        pb_p    = pb_reg;
        skip_p  = skip_reg || (fin_go && fin_a.err);
        if (proc_go) begin
            unique case (mode_c)
                MODE_WORD: begin
                    match_p = (run_reg < RUN_W'(6)) ?
                              (match_reg & word_hit(char_code, run_reg[2:0])) : 6'b0;
                    run_p   = run_inc;
                end
                MODE_NUM: begin
                    if (|acc_mul[AW-1:INT_BITS]) begin
                        acc_p = '1;
                        ovf_p = 1'b1;
                    end else begin
                        acc_p = acc_mul[INT_BITS-1:0];
                    end
                    run_p = run_inc;
                end
                MODE_SYM: begin
                    if (run_reg < RUN_W'(2)) begin
                        pa_p = pb_reg;
                        pb_p = char_code;
                    end
                    skip_p = ps_err;
                    run_p  = run_inc;
                end
                MODE_IDLE: begin
                    if (is_alpha) begin
                        mode_p  = MODE_WORD;
                        start_p = col_reg;
                        run_p   = RUN_W'(1);
                        match_p = word_hit(char_code, 3'd0);
                    end else if (is_digit) begin
                        mode_p  = MODE_NUM;
                        start_p = col_reg;
                        run_p   = RUN_W'(1);
                        acc_p   = INT_BITS'(char_code[3:0]);
                        ovf_p   = 1'b0;
                    end else if (is_sym) begin
                        mode_p  = MODE_SYM;
                        start_p = col_reg;
                        run_p   = RUN_W'(1);
                        pa_p    = 8'd0;
                        pb_p    = char_code;
                    end else begin
                        skip_p = ps_err;
                    end
                end
            endcase
        end
        end_go = line_end && proc_go && !skip_p;

        mode_next = line_end ? MODE_IDLE : mode_p;
        skip_next = line_end ? 1'b0 : skip_p;
        run_next  = line_end ? '0 : run_p;
        if (line_end) col_next = '0;
        else if (col_reg < COL_W'(MAX_LINE - 1)) col_next = col_reg + 1'b1;
        else col_next = col_reg;
    end

    // gather candidates in order and pack them
    always_comb begin
        logic [2:0] n;
        fin_e = finish(mode_p, match_p, run_p, start_p, acc_p, ovf_p, pa_p, pb_p);
        cand[0] = fin_a.r0;
        cand[1] = fin_a.r1;
        cand[2] = ps0;
        cand[3] = ps1;
        cand[4] = ps2;
        cand[5] = fin_e.r0;
        cand[6] = fin_e.r1;
        cand_vld = {fin_e.vld & {2{end_go}}, ps_vld, fin_a.vld & {2{fin_go}}};
        n = 3'd0;
        bundle_o = '0;
        for (int j = 0; j < 7; j++) begin
            if (cand_vld[j] && n < 3'(MAX_RES)) begin
                bundle_o.tok[n[1:0]] = cand[j];
                n = n + 1'b1;
            end
        end
        bundle_o.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            skip_reg <= 1'b0;
            col_reg  <= '0;
            run_reg  <= '0;
        end else if (fire) begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
            col_reg  <= col_next;
            run_reg  <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            match_reg <= match_p;
            start_reg <= start_p;
            acc_reg   <= acc_p;
            ovf_reg   <= ovf_p;
            pa_reg    <= pa_p;
            pb_reg    <= pb_p;
        end
    end

    `ASSERT_NEXT(a_line_restart, aclk, aresetn, fire && line_end, col_reg == '0 && !skip_reg && mode_reg == MODE_IDLE, "line state not cleared after last character")
    `ASSERT_IMPL(a_max_results, aclk, aresetn, fire, bundle_o.cnt <= 3'd3, "more than three results for one character")
    `ASSERT_ALWAYS(a_run_cap, aclk, aresetn, run_reg <= RUN_W'(MAX_LINE), "run length beyond line limit")

endmodule

// ===== rtl/core/slt_serializer.sv =====
// ---------------------------------------------------------------------------
// slt_serializer
// Holds the results of one character and issues them one per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slt_serializer
    import slt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  bundle_t bundle_i,
    output logic    ready_o,
    input  logic    m_ready,
    output logic    m_valid,
    output logic    m_last,
    output tok_t    tok_o
);

    tok_t [MAX_RES-1:0] bnd_reg;
    logic [2:0]         cnt_reg;
    logic [1:0]         idx_reg;
    logic [2:0]         idx_ext;
    logic               has, pop, pop_last;
    tok_t               out_tok_reg;
    logic               out_valid_reg, out_last_reg;

    assign idx_ext  = {1'b0, idx_reg};
    assign has      = cnt_reg != 3'd0;
    assign pop      = has && (!out_valid_reg || m_ready);
    assign pop_last = pop && (idx_ext == cnt_reg - 3'd1);
    // free once the last held result moves to the output register
    assign ready_o  = !has || pop_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= 3'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                cnt_reg <= bundle_i.cnt;
                idx_reg <= 2'd0;
            end else if (pop_last) begin
                cnt_reg <= 3'd0;
                idx_reg <= 2'd0;
            end else if (pop) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (pop) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) bnd_reg <= bundle_i.tok;
        if (pop) begin
            out_tok_reg  <= bnd_reg[idx_reg];
            out_last_reg <= pop_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_last  = out_last_reg;
    assign tok_o   = out_tok_reg;

    `ASSERT_IMPL(a_idx_range, aclk, aresetn, has, idx_ext < cnt_reg, "read index past held results")
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, out_valid_reg && !m_ready && has, $stable(idx_reg) && $stable(cnt_reg), "held results moved during output stall")
    `ASSERT_IMPL(a_load_free, aclk, aresetn, load, ready_o, "results loaded over pending ones")

endmodule

// ===== rtl/core/source_line_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// source_line_tokenizer_unit
// Streaming lexer for source lines: one character in per transaction, tokens out.
// ---------------------------------------------------------------------------
//  channel | direction | tdata                     | tuser          | tlast
//  s_axis  | in        | char_code                 | -              | line_end
//  m_axis  | out       | value, ovf, col, length   | kind, status   | last of char
//
//  One character is taken per cycle while each yields at most one token and
//  m_axis does not stall; one that closes or emits N tokens (N at most 3) keeps
//  the input stalled until its last result moves on, as results leave one per
//  transaction through the single output register. Results are held in the
//  serializer on acceptance, then pass to the output register, which drives m_axis.
//  Reset (aresetn, synchronous) returns the scanner to the start of a line.
//  m_axis_tready low stalls results; the input keeps flowing until the held
//  results of the previous character can no longer drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_line_tokenizer_unit
    import slt_pkg::*;
#(
    parameter int MAX_LINE = 1024,  // column saturates at MAX_LINE-1
    parameter int INT_BITS = 32     // integer literal accumulator width
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // line_end

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] int_value, [32] overflow,
                                        // [42:33] start_col, [53:43] length, [55:54] zero
    output logic [6:0]  m_axis_tuser,   // [4:0] token_kind, [6:5] status
    output logic        m_axis_tlast    // last result of this character
);

    logic    s_fire;
    bundle_t bundle;
    tok_t    out_tok;

    // a character transaction completes here
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // scanner state plus all results of the current character
    slt_lexer #(
        .MAX_LINE (MAX_LINE),
        .INT_BITS (INT_BITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s_fire),
        .char_code (s_axis_tdata),
        .line_end  (s_axis_tlast),
        .bundle_o  (bundle)
    );

    // hands the results out one per output transaction
    slt_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_fire),
        .bundle_i (bundle),
        .ready_o  (s_axis_tready),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_last   (m_axis_tlast),
        .tok_o    (out_tok)
    );

    assign m_axis_tdata = {2'b00, out_tok.len, out_tok.col, out_tok.ovf, out_tok.value};
    assign m_axis_tuser = {out_tok.status, out_tok.kind};

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for source_line_tokenizer_unit. Characters go in over
// s_axis with random gaps. A scoreboard class predicts the tokens of each
// character and checks every m_axis transaction field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import slt_pkg::*;

    localparam int RANDOM_ITEMS   = 160;
    localparam int QUIET_ITEMS    = 40;    // tail of the run with no idling
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int STALL_LIMIT    = 1000;
    localparam int MAX_PRINTS     = 100;

    // one expected token, widths as on the m_axis fields
    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [31:0] value;
        logic        ovf;
        logic [9:0]  col;
        logic [10:0] len;
        logic        last;
    } token_rec_t;

    // -----------------------------------------------------------------------
    // Lexer predictor plus expected-token queue
    // -----------------------------------------------------------------------
    class token_scoreboard;
        localparam int LINE_MAX = 1024;
        localparam longint unsigned LIT_MAX = 64'hFFFF_FFFF;

        mode_t        scan_state;
        logic [5:0]   kw_hits;    // struct, if, while, for, true, false
        logic [9:0]   col_pos;
        logic [9:0]   tok_col;
        logic [10:0]  tok_len;
        longint unsigned lit_acc;
        logic         lit_ovf;
        logic [15:0]  sym_hist;
        logic         skip_line;

        token_rec_t   step_toks[$];
        token_rec_t   tokens_due[$];
        int           mismatches;

        function new();
            scan_state = MODE_IDLE;
            kw_hits    = '0;
            col_pos    = '0;
            tok_col    = '0;
            tok_len    = '0;
            lit_acc    = 0;
            lit_ovf    = 1'b0;
            sym_hist   = '0;
            skip_line  = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function string keyword_word(int idx);
            case (idx)
                0:       return "struct";
                1:       return "if";
                2:       return "while";
                3:       return "for";
                4:       return "true";
                default: return "false";
            endcase
        endfunction

        function kind_t keyword_kind(int idx);
            case (idx)
                0:       return K_STRUCT;
                1:       return K_IF;
                2:       return K_WHILE;
                3:       return K_FOR;
                default: return K_BOOL;
            endcase
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_symbol(logic [7:0] c);
            case (c)
                "(", ")", "{", "}", ";", ",", "=", "+", "-", "*", "/", "<", ">",
                "|", "&", "^": return 1'b1;
                default:       return 1'b0;
            endcase
        endfunction

        // K_IDENT: no token of its own (lone | or &)
        function kind_t symbol_kind(logic [7:0] c);
            case (c)
                "(":     return K_LPAREN;
                ")":     return K_RPAREN;
                "{":     return K_LBRACE;
                "}":     return K_RBRACE;
                ";":     return K_SEMI;
                ",":     return K_COMMA;
                "=":     return K_ASSIGN;
                "+":     return K_PLUS;
                "-":     return K_MINUS;
                "*":     return K_STAR;
                "/":     return K_SLASH;
                "<":     return K_LT;
                ">":     return K_GT;
                "^":     return K_XOR;
                default: return K_IDENT;
            endcase
        endfunction

        function logic [10:0] grow(logic [10:0] n);
            return (n < LINE_MAX) ? n + 11'd1 : 11'(LINE_MAX);
        endfunction

        function void push_token(kind_t k, status_t s, logic [31:0] v, logic o,
                                 logic [9:0] c, logic [10:0] n);
            token_rec_t t;
            if (step_toks.size() >= MAX_RES) return;
            t.kind   = k;
            t.status = s;
            t.value  = v;
            t.ovf    = o;
            t.col    = c;
            t.len    = n;
            t.last   = 1'b0;
            step_toks = {step_toks, t};
        endfunction

        function void push_symbol(logic [7:0] c, logic [9:0] at);
            kind_t k;
            k = symbol_kind(c);
            if (k == K_IDENT) begin
                push_token(K_IDENT, ST_BAD_SYM, '0, 1'b0, at, 11'd1);
                skip_line = 1'b1;
            end else begin
                push_token(k, ST_OK, '0, 1'b0, at, 11'd1);
            end
        endfunction

        // drop every keyword that does not have c at position pos
        function void advance_keywords(logic [7:0] c, int pos);
            string w;
            for (int i = 0; i < 6; i++) begin
                w = keyword_word(i);
                if (pos >= w.len()) kw_hits[i] = 1'b0;
                else if (8'(w[pos]) != c) kw_hits[i] = 1'b0;
            end
        endfunction

        function void close_token();
            string      w;
            bit         found;
            logic [7:0] a, b;
            found = 1'b0;
            a = sym_hist[15:8];
            b = sym_hist[7:0];
            case (scan_state)
                MODE_WORD: begin
                    for (int i = 0; i < 6; i++) begin
                        w = keyword_word(i);
                        if (!found && kw_hits[i] && w.len() == tok_len) begin
                            push_token(keyword_kind(i), ST_OK, (i == 4) ? 32'd1 : 32'd0,
                                       1'b0, tok_col, tok_len);
                            found = 1'b1;
                        end
                    end
                    if (!found) push_token(K_IDENT, ST_OK, '0, 1'b0, tok_col, tok_len);
                end
                MODE_NUM:
                    push_token(K_INT, ST_OK, lit_acc[31:0], lit_ovf, tok_col, tok_len);
                MODE_SYM: begin
                    if (tok_len == 11'd1) begin
                        push_symbol(b, tok_col);
                    end else if (tok_len == 11'd2) begin
                        if (a == "=" && b == "=")
                            push_token(K_EQ, ST_OK, '0, 1'b0, tok_col, 11'd2);
                        else if (a == "|" && b == "|")
                            push_token(K_OR, ST_OK, '0, 1'b0, tok_col, 11'd2);
                        else if (a == "&" && b == "&")
                            push_token(K_AND, ST_OK, '0, 1'b0, tok_col, 11'd2);
                        else begin
                            push_symbol(a, tok_col);
                            if (!skip_line) push_symbol(b, tok_col + 10'd1);
                        end
                    end
                    // three or more: already sent one by one
                end
                default: ;
            endcase
            scan_state = MODE_IDLE;
        endfunction

        // one accepted s_axis transaction
        function void take_char(logic [7:0] c, logic eol);
            longint unsigned d;
            step_toks.delete();
            if (!skip_line) begin
                if ((scan_state == MODE_WORD && !is_letter(c) && !is_digit(c)) ||
                    (scan_state == MODE_NUM && !is_digit(c)) ||
                    (scan_state == MODE_SYM && !is_symbol(c)))
                    close_token();
            end
            if (!skip_line) begin
                case (scan_state)
                    MODE_WORD: begin
                        advance_keywords(c, int'(tok_len));
                        tok_len = grow(tok_len);
                    end
                    MODE_NUM: begin
                        d = c - "0";
                        if (lit_acc > (LIT_MAX - d) / 10) begin
                            lit_acc = LIT_MAX;
                            lit_ovf = 1'b1;
                        end else begin
                            lit_acc = lit_acc * 10 + d;
                        end
                        tok_len = grow(tok_len);
                    end
                    MODE_SYM: begin
                        if (tok_len < 11'd2) begin
                            sym_hist = {sym_hist[7:0], c};
                        end else if (tok_len == 11'd2) begin
                            // run reaches three: flush the pair, then go char by char
                            push_symbol(sym_hist[15:8], tok_col);
                            if (!skip_line) push_symbol(sym_hist[7:0], tok_col + 10'd1);
                            if (!skip_line) push_symbol(c, col_pos);
                        end else begin
                            push_symbol(c, col_pos);
                        end
                        tok_len = grow(tok_len);
                    end
                    default: begin
                        if (c == " ") begin
                            // separator
                        end else if (is_letter(c)) begin
                            scan_state = MODE_WORD;
                            tok_col    = col_pos;
                            tok_len    = 11'd1;
                            kw_hits    = '1;
                            advance_keywords(c, 0);
                        end else if (is_digit(c)) begin
                            scan_state = MODE_NUM;
                            tok_col    = col_pos;
                            tok_len    = 11'd1;
                            lit_acc    = c - "0";
                            lit_ovf    = 1'b0;
                        end else if (is_symbol(c)) begin
                            scan_state = MODE_SYM;
                            tok_col    = col_pos;
                            tok_len    = 11'd1;
                            sym_hist   = {8'h00, c};
                        end else begin
                            push_token(K_IDENT, ST_BAD_CHAR, '0, 1'b0, col_pos, 11'd1);
                            skip_line = 1'b1;
                        end
                    end
                endcase
                if (eol && !skip_line) close_token();
            end
            if (col_pos < LINE_MAX - 1) col_pos = col_pos + 10'd1;
            if (eol) begin
                scan_state = MODE_IDLE;
                col_pos    = '0;
                skip_line  = 1'b0;
                tok_len    = '0;
                sym_hist   = '0;
            end
            foreach (step_toks[i]) begin
                token_rec_t t;
                t = step_toks[i];
                t.last = (i == step_toks.size() - 1);
                tokens_due = {tokens_due, t};
            end
        endfunction

        task report(string what, longint got, longint want);
            if (mismatches < MAX_PRINTS)
                $display("mismatch %s: got %0d, expected %0d", what, got, want);
            mismatches++;
        endtask

        // one accepted m_axis transaction
        task check_token(logic [55:0] d, logic [6:0] u, logic l);
            token_rec_t e;
            if (tokens_due.size() == 0) begin
                report("token with none pending, kind", u[4:0], -1);
                return;
            end
            e = tokens_due.pop_front();
            if (u[4:0]   !== e.kind)   report("token_kind", u[4:0], e.kind);
            if (u[6:5]   !== e.status) report("status", u[6:5], e.status);
            if (d[31:0]  !== e.value)  report("int_value", d[31:0], e.value);
            if (d[32]    !== e.ovf)    report("overflow", d[32], e.ovf);
            if (d[42:33] !== e.col)    report("start_col", d[42:33], e.col);
            if (d[53:43] !== e.len)    report("length", d[53:43], e.len);
            if (d[55:54] !== 2'b00)    report("tdata pad", d[55:54], 0);
            if (l        !== e.last)   report("tlast", l, e.last);
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Clock, DUT
    // -----------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [6:0]  m_axis_tuser;
    logic        m_axis_tlast;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    source_line_tokenizer_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    token_scoreboard sb;
    bit              quiet       = 1'b0;  // no idling on either side
    bit              holdoff_req = 1'b0;
    logic [7:0]      line_q[$];
    int              stalled_cycles = 0;

    // -----------------------------------------------------------------------
    // Character source; every call starts and ends at a falling edge
    // -----------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic eol);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eol;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.take_char(c, eol);
        @(negedge aclk);
    endtask

    task automatic send_text(input string s, input logic close_line);
        for (int i = 0; i < s.len(); i++)
            send_char(8'(s[i]), close_line && (i == s.len() - 1));
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
    endtask

    // sender pause until the token queue is empty
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic void add_char(logic [7:0] c);
        line_q = {line_q, c};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(8'(s[i]));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) != 0) return 8'($urandom_range(97, 122));
        return 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 3) == 0) return rand_digit();
        return rand_letter();
    endfunction

    function automatic logic [7:0] rand_symbol();
        string syms;
        syms = "(){};,=+-*/<>|&^";
        return 8'(syms[$urandom_range(0, 15)]);
    endfunction

    // a line of mostly well-formed tokens with some noise mixed in
    task automatic build_line();
        int    ntok, pick, n;
        string w;
        line_q.delete();
        ntok = $urandom_range(1, 6);
        repeat (ntok) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                add_text(sb.keyword_word($urandom_range(0, 5)));
            end else if (pick < 22) begin
                // near-miss keyword: one short or one long
                w = sb.keyword_word($urandom_range(0, 5));
                if ($urandom_range(0, 1) != 0) begin
                    add_text(w.substr(0, w.len() - 2));
                end else begin
                    add_text(w);
                    add_char(rand_alnum());
                end
            end else if (pick < 36) begin
                add_char(rand_letter());
                repeat ($urandom_range(0, 6)) add_char(rand_alnum());
            end else if (pick < 52) begin
                case ($urandom_range(0, 9))
                    0:       add_text($urandom_range(0, 1) ? "4294967295" : "4294967296");
                    1, 2:    repeat ($urandom_range(9, 12)) add_char(rand_digit());
                    default: repeat ($urandom_range(1, 4)) add_char(rand_digit());
                endcase
            end else if (pick < 82) begin
                case ($urandom_range(0, 9))
                    5:       add_text("==");
                    6:       add_text("||");
                    7:       add_text("&&");
                    8, 9: begin
                        n = $urandom_range(2, 5);
                        repeat (n) add_char(rand_symbol());
                    end
                    default: add_char(rand_symbol());
                endcase
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) add_char(" ");
            end else begin
                add_char(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) < 7) add_char(" ");
        end
    endtask

    // -----------------------------------------------------------------------
    // Result sink: random stall bursts, one long hold-off on request
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (holdoff_req && !quiet) begin
                holdoff_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge aclk);
            end
            if (quiet) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin : stimulus
        int rand_items, line_no;
        sb = new();
        rand_items = 0;
        line_no    = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed lines
        send_text("if a==12", 1'b1);     // keyword, ident, pair, int
        send_text("+-*/", 1'b1);         // symbol run past two
        send_char("7", 1'b0);            // int then bad char in one step
        send_char(8'h00, 1'b0);
        send_char("x", 1'b1);            // skipped
        send_char(8'hFF, 1'b1);
        send_text("|", 1'b1);            // lone pipe
        send_text("true", 1'b1);         // closed by end of line
        send_text("a&", 1'b1);           // lone ampersand at end

        while (rand_items < RANDOM_ITEMS) begin
            quiet = (rand_items >= RANDOM_ITEMS - QUIET_ITEMS);
            if (line_no == 3) begin
                // output held long while input keeps coming
                holdoff_req = 1'b1;
                line_q.delete();
                add_text("x1 + y2 ; z3 ( 4 ) == w5");
            end else if (line_no == 6) begin
                // sender pause: every expected token drains first
                wait_for_drain();
                build_line();
            end else begin
                build_line();
            end
            send_line();
            rand_items += line_q.size();
            line_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
